[src/iso2kr_pkg.sv]
// ----------------------------------------------------------------------------
// iso2kr_pkg : shared types and constants for the ISO-2022-KR decoder
// Character codes, designator prefix lookup, byte mapping and the group
// descriptor passed from the decode logic to the result register.
// ----------------------------------------------------------------------------
package iso2kr_pkg;

   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_FINAL_UC = 8'h43;
   localparam logic [7:0] CH_FINAL_LC = 8'h63;
   localparam logic [7:0] CH_SO       = 8'h0e;
   localparam logic [7:0] CH_SI       = 8'h0f;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] HIGH_BIT    = 8'h80;

   // results raised by one input byte: up to three held bytes plus one more
   typedef struct packed {
      logic       dbl_mode;    // mode the whole group is emitted under
      logic [1:0] held_cnt;    // leading designator bytes to replay
      logic       has_extra;   // one further byte follows the held ones
      logic [7:0] extra_byte;
   } grp_type;

   // byte of ESC $ ) at a given position
   function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
      logic [7:0] res;
      case (idx)
         2'd0:    res = CH_ESC;
         2'd1:    res = CH_DOLLAR;
         2'd2:    res = CH_RPAREN;
         default: res = CH_ESC;
      endcase
      return res;
   endfunction

   function automatic logic [7:0] map_byte(input logic [7:0] b, input logic dbl);
      logic [7:0] res;
      if (dbl && (b != CH_SPACE) && (b != CH_TAB)) begin
         res = b | HIGH_BIT;
      end else begin
         res = b;
      end
      return res;
   endfunction

endpackage

[src/iso2022kr_to_ksc5601_decoder.sv]
// ----------------------------------------------------------------------------
// iso2022kr_to_ksc5601_decoder : ISO-2022-KR to KSC5601 byte decoder
// Strips the ESC $ ) C or c designator, tracks SO/SI shift state and sets the top
// bit of bytes other than space and tab in double-byte mode.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  req     | req_valid/ready, req_in_byte/last  | in, one text byte per transfer
//  rsp     | rsp_valid/ready, rsp_out_byte/last | out, 0..4 bytes per input byte
//
//  A byte giving one result is taken every cycle while rsp is not stalled; the
//  result appears the cycle after its input transfer. A byte giving n results
//  (a replayed designator prefix) holds off req_ready while the result register
//  drains one byte a cycle unless rsp stalls; a byte giving none leaves it empty.
//  Synchronous active-high reset returns to ASCII mode with nothing held.
//  A stalled rsp holds the result register and thus the input side.
// ----------------------------------------------------------------------------
module iso2022kr_to_ksc5601_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic                dbl_mode_ff, dbl_mode_in;
   logic [1:0]          match_cnt_ff, match_cnt_in;
   iso2kr_pkg::grp_type grp_ff, grp_in;
   logic [2:0]          rem_ff;
   logic [1:0]          pos_ff;
   logic                req_xfer, rsp_xfer;
   logic [2:0]          grp_n;
   logic [7:0]          raw_byte;

   iso2kr_decode u_decode (
      .dbl_mode      (dbl_mode_ff),
      .match_cnt     (match_cnt_ff),
      .in_byte       (req_in_byte),
      .in_last       (req_in_last),
      .dbl_mode_nxt  (dbl_mode_in),
      .match_cnt_nxt (match_cnt_in),
      .grp           (grp_in)
   );

   assign grp_n     = {1'b0, grp_in.held_cnt} + {2'b00, grp_in.has_extra};
   assign rsp_valid = (rem_ff != 3'd0);
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign req_ready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ready);
   assign req_xfer  = req_valid && req_ready;

   assign raw_byte     = (pos_ff < grp_ff.held_cnt) ? iso2kr_pkg::prefix_byte(pos_ff)
                                                    : grp_ff.extra_byte;
   assign rsp_out_byte = iso2kr_pkg::map_byte(raw_byte, grp_ff.dbl_mode);
   assign rsp_out_last = (rem_ff == 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_mode_ff  <= 1'b0;
         match_cnt_ff <= 2'd0;
         rem_ff       <= 3'd0;
         pos_ff       <= 2'd0;
      end else begin
         if (req_xfer) begin
            dbl_mode_ff  <= dbl_mode_in;
            match_cnt_ff <= match_cnt_in;
         end
         // a new group only loads once the previous one is on its last byte
         if (req_xfer && (grp_n != 3'd0)) begin
            rem_ff <= grp_n;
            pos_ff <= 2'd0;
         end else if (rsp_xfer) begin
            rem_ff <= rem_ff - 3'd1;
            pos_ff <= pos_ff + 2'd1;
         end
      end
   end

   // group payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer && (grp_n != 3'd0)) begin
         grp_ff <= grp_in;
      end
   end

endmodule

[src/iso2kr_decode.sv]
// ----------------------------------------------------------------------------
// iso2kr_decode : per-byte decode step
// From the current mode and designator match count, works out the next state
// and the group of bytes the incoming byte releases.
// ----------------------------------------------------------------------------
module iso2kr_decode (
   input  logic                  dbl_mode,
   input  logic [1:0]            match_cnt,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output logic                  dbl_mode_nxt,
   output logic [1:0]            match_cnt_nxt,
   output iso2kr_pkg::grp_type   grp
);

   logic complete;
   logic advance;

   assign complete = (match_cnt == 2'd3) &&
                     ((in_byte == iso2kr_pkg::CH_FINAL_UC) ||
                      (in_byte == iso2kr_pkg::CH_FINAL_LC));
   assign advance  = (match_cnt != 2'd0) && (match_cnt != 2'd3) &&
                     (in_byte == iso2kr_pkg::prefix_byte(match_cnt));

   always_comb begin
      dbl_mode_nxt   = dbl_mode;
      match_cnt_nxt  = 2'd0;
      grp.dbl_mode   = dbl_mode;
      grp.held_cnt   = 2'd0;
      grp.has_extra  = 1'b0;
      grp.extra_byte = in_byte;
      if (complete) begin
         match_cnt_nxt = 2'd0;
      end else if (advance) begin
         if (in_last) begin
            grp.held_cnt = match_cnt + 2'd1;
         end else begin
            match_cnt_nxt = match_cnt + 2'd1;
         end
      end else begin
         // mismatch: replay held bytes, then treat this byte as new
         grp.held_cnt = match_cnt;
         if (in_byte == iso2kr_pkg::CH_ESC) begin
            if (in_last) begin
               grp.has_extra = 1'b1;
            end else begin
               match_cnt_nxt = 2'd1;
            end
         end else if (in_byte == iso2kr_pkg::CH_SO) begin
            dbl_mode_nxt = 1'b1;
         end else if (in_byte == iso2kr_pkg::CH_SI) begin
            dbl_mode_nxt = 1'b0;
         end else begin
            grp.has_extra = 1'b1;
         end
      end
   end

endmodule

[bench/tb_iso2022kr_to_ksc5601_decoder.sv]
// ----------------------------------------------------------------------------
// tb_iso2022kr_to_ksc5601_decoder : self-checking bench for the KR decoder
// A directed byte sequence covers designator stripping in both letter cases,
// SO/SI shifts, space and tab, replay of held prefixes at every depth, ESC
// restart and last-flag flushing. Random text follows: mostly designators and
// shifted runs, plus broken prefixes and noise. Each output transfer is
// compared with a behavioural decoder, first with the sink stalling heavily,
// then the source, then with neither idling.
// ----------------------------------------------------------------------------
module tb_iso2022kr_to_ksc5601_decoder;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } ksc_byte_type;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic [7:0] req_in_byte  = 8'h01;
   logic       req_in_last  = 1'b0;
   logic       rsp_ready    = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   // decoder state as predicted
   logic       dbl_mode = 1'b0;
   logic [1:0] held_cnt = 2'd0;

   ksc_byte_type ksc_pending_q [$];
   ksc_byte_type grp_buf [4];
   int           grp_len;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int err_count = 0;
   int items_sent = 0;
   int bytes_checked = 0;
   int desig_stripped = 0;
   int widest_group = 0;
   int cycle_cnt = 0;

   iso2022kr_to_ksc5601_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [7:0] designator_prefix(input int idx);
      logic [7:0] code;
      case (idx)
         0:       code = iso2kr_pkg::CH_ESC;
         1:       code = iso2kr_pkg::CH_DOLLAR;
         default: code = iso2kr_pkg::CH_RPAREN;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] shift_code(input logic [7:0] b);
      logic [7:0] code;
      code = b;
      if (dbl_mode && b != iso2kr_pkg::CH_SPACE && b != iso2kr_pkg::CH_TAB) begin
         code = b | iso2kr_pkg::HIGH_BIT;
      end
      return code;
   endfunction

   task automatic emit_code(input logic [7:0] code);
      grp_buf[grp_len] = '{code: code, last: 1'b0};
      grp_len++;
   endtask

   task automatic replay_held();
      for (int k = 0; k < held_cnt; k++) begin
         emit_code(shift_code(designator_prefix(k)));
      end
      held_cnt = 2'd0;
   endtask

   task automatic take_fresh(input logic [7:0] b);
      if (b == iso2kr_pkg::CH_ESC) begin
         held_cnt = 2'd1;
      end else if (b == iso2kr_pkg::CH_SO) begin
         dbl_mode = 1'b1;
      end else if (b == iso2kr_pkg::CH_SI) begin
         dbl_mode = 1'b0;
      end else begin
         emit_code(shift_code(b));
      end
   endtask

   task automatic decode_iso_byte(input logic [7:0] b, input logic l);
      grp_len = 0;
      if (held_cnt == 2'd3) begin
         if (b == iso2kr_pkg::CH_FINAL_UC || b == iso2kr_pkg::CH_FINAL_LC) begin
            held_cnt = 2'd0;
            desig_stripped++;
         end else begin
            replay_held();
            take_fresh(b);
         end
      end else if (held_cnt != 2'd0 && b == designator_prefix(held_cnt)) begin
         held_cnt = held_cnt + 2'd1;
      end else begin
         replay_held();
         take_fresh(b);
      end
      if (l) begin
         replay_held();
      end
      if (grp_len > 0) begin
         grp_buf[grp_len - 1].last = 1'b1;
      end
      if (grp_len > widest_group) begin
         widest_group = grp_len;
      end
      for (int k = 0; k < grp_len; k++) begin
         ksc_pending_q.push_back(grp_buf[k]);
      end
   endtask

   // ---------------------------------------------------------------- source
   // prediction goes in ahead of the transfer; its results cannot come earlier
   task automatic send_item(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      decode_iso_byte(b, l);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   function automatic logic coin_last();
      return ($urandom_range(7) == 0);
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      case ($urandom_range(9))
         0:       b = iso2kr_pkg::CH_SPACE;
         1:       b = iso2kr_pkg::CH_TAB;
         default: b = 8'($urandom_range(1, 255));
      endcase
      return b;
   endfunction

   task automatic set_idling(input int src_pct, input int snk_pct);
      send_idle_pct = src_pct;
      recv_idle_pct = snk_pct;
   endtask

   // ---------------------------------------------------------------- sink
   task automatic report_mismatch(input string what);
      $display("[%0d] mismatch: %s", cycle_cnt, what);
      err_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      ksc_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ksc_pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
         end else begin
            want = ksc_pending_q.pop_front();
            if (rsp_out_byte !== want.code) begin
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_out_byte, want.code));
            end
            if (rsp_out_last !== want.last) begin
               report_mismatch($sformatf("out_last %0b, want %0b on byte %02h",
                                         rsp_out_last, want.last, want.code));
            end
            bytes_checked++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- tests
   task automatic test_directed_cases();
      send_item(8'h01, 1'b0);
      send_item(8'hff, 1'b1);
      // full designator, upper case, stripped
      send_item(iso2kr_pkg::CH_ESC, 1'b0);
      send_item(iso2kr_pkg::CH_DOLLAR, 1'b0);
      send_item(iso2kr_pkg::CH_RPAREN, 1'b0);
      send_item(iso2kr_pkg::CH_FINAL_UC, 1'b0);
      send_item(iso2kr_pkg::CH_SO, 1'b0);
      send_item(8'h41, 1'b0);
      send_item(iso2kr_pkg::CH_SPACE, 1'b0);
      send_item(iso2kr_pkg::CH_TAB, 1'b0);
      // second ESC replays the first and restarts the match
      send_item(iso2kr_pkg::CH_ESC, 1'b0);
      send_item(iso2kr_pkg::CH_ESC, 1'b0);
      send_item(iso2kr_pkg::CH_DOLLAR, 1'b0);
      send_item(8'h78, 1'b0);
      // three held plus a mismatch: widest group
      send_item(iso2kr_pkg::CH_ESC, 1'b0);
      send_item(iso2kr_pkg::CH_DOLLAR, 1'b0);
      send_item(iso2kr_pkg::CH_RPAREN, 1'b0);
      send_item(8'h51, 1'b0);
      // lower-case final letter inside double-byte text
      send_item(iso2kr_pkg::CH_ESC, 1'b0);
      send_item(iso2kr_pkg::CH_DOLLAR, 1'b0);
      send_item(iso2kr_pkg::CH_RPAREN, 1'b0);
      send_item(iso2kr_pkg::CH_FINAL_LC, 1'b0);
      send_item(iso2kr_pkg::CH_SI, 1'b0);
      // end of text with a partial prefix held
      send_item(iso2kr_pkg::CH_ESC, 1'b0);
      send_item(iso2kr_pkg::CH_DOLLAR, 1'b1);
   endtask

   task automatic test_random_text(input int n_items);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            send_item(iso2kr_pkg::CH_ESC, 1'b0);
            send_item(iso2kr_pkg::CH_DOLLAR, 1'b0);
            send_item(iso2kr_pkg::CH_RPAREN, 1'b0);
            send_item($urandom_range(1) ? iso2kr_pkg::CH_FINAL_UC
                                        : iso2kr_pkg::CH_FINAL_LC, coin_last());
            sent += 4;
         end else if (kind < 70) begin
            len = $urandom_range(1, 6);
            send_item(iso2kr_pkg::CH_SO, 1'b0);
            for (int k = 0; k < len; k++) begin
               send_item(text_byte(), coin_last());
            end
            send_item(iso2kr_pkg::CH_SI, coin_last());
            sent += len + 2;
         end else if (kind < 85) begin
            // broken designator, optionally cut short by the last flag
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
               send_item(designator_prefix(k), (k == len - 1) ? coin_last() : 1'b0);
            end
            send_item(text_byte(), coin_last());
            sent += len + 1;
         end else begin
            send_item(8'($urandom_range(1, 255)), coin_last());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(22, 86);
      test_directed_cases();
      test_random_text(130);
      set_idling(86, 22);
      test_random_text(130);
      set_idling(0, 0);
      test_random_text(140);

      req_valid <= 1'b0;
      while (ksc_pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d text bytes, checked %0d output bytes, %0d designators removed.",
               items_sent, bytes_checked, desig_stripped);
      $display("Widest output group %0d bytes; %0d mismatches.", widest_group, err_count);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("Timed out after %0d cycles with %0d bytes outstanding.",
               cycle_cnt, ksc_pending_q.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/iso2kr_pkg.sv
src/iso2kr_decode.sv
src/iso2022kr_to_ksc5601_decoder.sv
bench/tb_iso2022kr_to_ksc5601_decoder.sv
